FILE: rtl/ais_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the alternating IIR slew shaper.
// Used by the controller, the datapath and the top level; depends on nothing.

package ais_pkg;

   localparam int STATE_W   = 32;
   localparam int COEF_W    = 25;
   localparam int SAMPLE_W  = 24;
   localparam int VOICE_W   = 4;
   localparam int CSR_IDX_W = 2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_STAGE_COEF = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IIR_COEF         = 2'd1;

   localparam logic [COEF_W-1:0] FIRST_STAGE_COEF_RESET = 25'd6408326;
   localparam logic [COEF_W-1:0] IIR_COEF_RESET         = 25'd49493;

   // Slew limit of 0.381966 volt at 2^-28 volt per LSB.
   localparam logic signed [STATE_W:0] SLEW_LIMIT = 33'sd102533220;

   typedef struct packed {
      logic                       side;
      logic [VOICE_W-1:0]         voice;
      logic signed [SAMPLE_W-1:0] sample_in;
   } req_payload_type;

   typedef struct packed {
      logic                       side_out;
      logic [VOICE_W-1:0]         voice_out;
      logic signed [SAMPLE_W-1:0] sample_out;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      STAGE_FIRST,
      STAGE_SECOND,
      STAGE_THIRD
   } stage_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic          accept;
      logic          load;
      logic          mul;
      logic          acc;
      stage_sel_type stage;
      logic          commit;
      logic          deliver;
   } ais_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic in_range;
      logic out_free;
   } ais_status_type;

endpackage

FILE: rtl/ais_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the per-slot filter state.

module ais_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/ais_ctrl.sv
`timescale 1ns / 1ps
// Sequencing state machine of the alternating IIR slew shaper.
// Depends on ais_pkg for the command and status structs.

module ais_ctrl
   import ais_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  ais_status_type status,
   output ais_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MUL,
      ST_ACC,
      ST_COMMIT,
      ST_DELIVER
   } state_type;

   state_type     state_ff;
   state_type     state_in;
   stage_sel_type stage_ff;
   stage_sel_type stage_in;
   stage_sel_type stage_next;

   always_comb begin
      case (stage_ff)
         STAGE_FIRST:  stage_next = STAGE_SECOND;
         STAGE_SECOND: stage_next = STAGE_THIRD;
         default:      stage_next = STAGE_FIRST;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      stage_in = stage_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            stage_in = STAGE_FIRST;
            state_in = status.in_range ? ST_MUL : ST_DELIVER;
         end
         ST_MUL: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (stage_ff == STAGE_THIRD) begin
               state_in = ST_COMMIT;
            end else begin
               stage_in = stage_next;
               state_in = ST_MUL;
            end
         end
         ST_COMMIT: begin
            state_in = ST_DELIVER;
         end
         ST_DELIVER: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         stage_ff <= STAGE_FIRST;
      end else begin
         state_ff <= state_in;
         stage_ff <= stage_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      cmd         = '0;
      cmd.stage   = stage_ff;
      cmd.accept  = (state_ff == ST_IDLE) && req_valid;
      cmd.load    = (state_ff == ST_LOAD);
      cmd.mul     = (state_ff == ST_MUL);
      cmd.acc     = (state_ff == ST_ACC);
      cmd.commit  = (state_ff == ST_COMMIT);
      cmd.deliver = (state_ff == ST_DELIVER) && status.out_free;
   end

endmodule

FILE: rtl/ais_datapath.sv
`timescale 1ns / 1ps
// Datapath of the alternating IIR slew shaper: state RAMs, shared multiplier,
// clamp and output register. Depends on ais_pkg and ais_ram.

module ais_datapath
   import ais_pkg::*;
#(
   parameter int VOICES = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  req_payload_type       req_payload,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [COEF_W-1:0]     csr_data,
   input  ais_cmd_type           cmd,
   output ais_status_type        status,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_payload
);

   localparam int SLOTS     = 2 * VOICES;
   localparam int SLOT_W    = $clog2(SLOTS);
   localparam int ROW_DEPTH = 2 ** (SLOT_W + 1);
   localparam int ROW_W     = 3 * STATE_W;
   localparam int DRY_W     = SAMPLE_W + 4;
   localparam int PROD_W    = 2 * STATE_W - 5;
   localparam int WIDE_W    = STATE_W + 4;
   localparam logic [VOICE_W:0]    VOICE_LIMIT = (VOICE_W + 1)'(VOICES);
   localparam logic [SLOT_W-1:0]   SIDE_BASE   = SLOT_W'(VOICES);

   function automatic logic signed [STATE_W-1:0] sat_state(
      input logic signed [WIDE_W-1:0] v
   );
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] lo;
      hi = WIDE_W'(2147483647);
      lo = -hi - WIDE_W'(1);
      if (v > hi) begin
         return hi[STATE_W-1:0];
      end else if (v < lo) begin
         return lo[STATE_W-1:0];
      end
      return v[STATE_W-1:0];
   endfunction

   // Configuration.
   logic [COEF_W-1:0] first_coef_ff;
   logic [COEF_W-1:0] iir_coef_ff;

   // Per-slot bank toggle and written flags; an unwritten row reads as zero.
   logic use_a_ff   [SLOTS];
   logic wrote_a_ff [SLOTS];
   logic wrote_b_ff [SLOTS];

   // Captured transaction.
   req_payload_type   item_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic              bank_b_ff;
   logic              row_valid_ff;
   logic              prev_valid_ff;
   logic              in_range_ff;

   // Working registers.
   logic signed [STATE_W-1:0] s1_ff;
   logic signed [STATE_W-1:0] s2_ff;
   logic signed [STATE_W-1:0] s3_ff;
   logic signed [STATE_W-1:0] avg_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [STATE_W-1:0] prev_new_ff;

   rsp_payload_type rsp_payload_ff;
   logic            rsp_valid_ff;

   // Request decode.
   logic              req_in_range;
   logic [SLOT_W-1:0] req_slot;
   logic              req_bank_b;

   assign req_in_range = ({1'b0, req_payload.voice} < VOICE_LIMIT);
   assign req_slot     = req_payload.side ? SIDE_BASE + SLOT_W'(req_payload.voice)
                                          : SLOT_W'(req_payload.voice);
   assign req_bank_b   = !use_a_ff[req_slot];

   // State memories.
   logic [ROW_W-1:0]   row_rd;
   logic [ROW_W-1:0]   row_wr;
   logic [STATE_W-1:0] prev_rd;
   logic signed [STATE_W-1:0] clamp_val;

   assign row_wr = {s1_ff, s2_ff, s3_ff};

   ais_ram #(
      .WIDTH(ROW_W),
      .DEPTH(ROW_DEPTH)
   ) u_row_ram (
      .clock  (clock),
      .wr_en  (cmd.commit),
      .wr_addr({bank_b_ff, slot_ff}),
      .wr_data(row_wr),
      .rd_en  (cmd.accept),
      .rd_addr({req_bank_b, req_slot}),
      .rd_data(row_rd)
   );

   ais_ram #(
      .WIDTH(STATE_W),
      .DEPTH(SLOTS)
   ) u_prev_ram (
      .clock  (clock),
      .wr_en  (cmd.commit),
      .wr_addr(slot_ff),
      .wr_data(clamp_val),
      .rd_en  (cmd.accept),
      .rd_addr(req_slot),
      .rd_data(prev_rd)
   );

   // Load: rows that were never written read as zero.
   logic signed [DRY_W-1:0]   dry;
   logic signed [STATE_W-1:0] prev_val;
   logic signed [STATE_W:0]   avg_sum;

   assign dry      = $signed({item_ff.sample_in, 4'b0000});
   assign prev_val = prev_valid_ff ? $signed(prev_rd) : '0;
   assign avg_sum  = (STATE_W + 1)'(dry) + (STATE_W + 1)'(prev_val);

   // Shared multiply and accumulate for the three lowpass stages.
   logic signed [STATE_W-1:0] mul_x;
   logic signed [STATE_W-1:0] mul_s;
   logic [COEF_W-1:0]         mul_c;
   logic signed [STATE_W:0]   diff;
   logic signed [PROD_W-1:0]  prod_full;
   logic signed [PROD_W-1:0]  prod_round;
   logic signed [WIDE_W-1:0]  acc_sum;
   logic signed [STATE_W-1:0] acc_new;

   always_comb begin
      case (cmd.stage)
         STAGE_FIRST: begin
            mul_x = avg_ff;
            mul_s = s1_ff;
            mul_c = first_coef_ff;
         end
         STAGE_SECOND: begin
            mul_x = s1_ff;
            mul_s = s2_ff;
            mul_c = iir_coef_ff;
         end
         default: begin
            mul_x = s2_ff;
            mul_s = s3_ff;
            mul_c = iir_coef_ff;
         end
      endcase
   end

   assign diff       = (STATE_W + 1)'(mul_x) - (STATE_W + 1)'(mul_s);
   assign prod_full  = PROD_W'(diff) * PROD_W'($signed({1'b0, mul_c}));
   assign prod_round = prod_ff + PROD_W'(32'sd8388608);
   assign acc_sum    = WIDE_W'(mul_s) + WIDE_W'($signed(prod_round[PROD_W-1:24]));
   assign acc_new    = sat_state(acc_sum);

   // Highpass and slew clamp against the first stage.
   logic signed [WIDE_W-1:0] hp;
   logic signed [WIDE_W-1:0] hp_dev;
   logic signed [WIDE_W-1:0] limit;
   logic signed [WIDE_W-1:0] hp_clamped;

   assign hp     = WIDE_W'(dry) - WIDE_W'(s3_ff);
   assign limit  = WIDE_W'(SLEW_LIMIT);
   assign hp_dev = hp - WIDE_W'(s1_ff);

   always_comb begin
      if (hp_dev > limit) begin
         hp_clamped = WIDE_W'(s1_ff) + limit;
      end else if (hp_dev < -limit) begin
         hp_clamped = WIDE_W'(s1_ff) - limit;
      end else begin
         hp_clamped = hp;
      end
   end

   assign clamp_val = sat_state(hp_clamped);

   // Output scaling with rounding and 24-bit saturation.
   logic signed [STATE_W:0]      out_round;
   logic signed [STATE_W-4:0]    out_scaled;
   logic signed [SAMPLE_W-1:0]   out_sat;

   assign out_round  = (STATE_W + 1)'(prev_new_ff) + (STATE_W + 1)'(8);
   assign out_scaled = out_round[STATE_W:4];

   always_comb begin
      if (out_scaled > (STATE_W - 3)'(8388607)) begin
         out_sat = SAMPLE_W'(8388607);
      end else if (out_scaled < -(STATE_W - 3)'(8388608)) begin
         out_sat = -SAMPLE_W'(8388607) - SAMPLE_W'(1);
      end else begin
         out_sat = out_scaled[SAMPLE_W-1:0];
      end
   end

   // Control state: configuration, slot flags and output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         first_coef_ff <= FIRST_STAGE_COEF_RESET;
         iir_coef_ff   <= IIR_COEF_RESET;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            use_a_ff[i]   <= 1'b1;
            wrote_a_ff[i] <= 1'b0;
            wrote_b_ff[i] <= 1'b0;
         end
      end else begin
         if (csr_write && (csr_index == CSR_FIRST_STAGE_COEF)) begin
            first_coef_ff <= csr_data;
         end
         if (csr_write && (csr_index == CSR_IIR_COEF)) begin
            iir_coef_ff <= csr_data;
         end
         if (cmd.commit) begin
            use_a_ff[slot_ff] <= bank_b_ff;
            if (bank_b_ff) begin
               wrote_b_ff[slot_ff] <= 1'b1;
            end else begin
               wrote_a_ff[slot_ff] <= 1'b1;
            end
         end
         if (cmd.deliver) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         item_ff       <= req_payload;
         slot_ff       <= req_slot;
         bank_b_ff     <= req_bank_b;
         row_valid_ff  <= req_bank_b ? wrote_b_ff[req_slot] : wrote_a_ff[req_slot];
         prev_valid_ff <= wrote_a_ff[req_slot];
         in_range_ff   <= req_in_range;
      end
      if (cmd.load) begin
         s1_ff  <= row_valid_ff ? $signed(row_rd[3*STATE_W-1:2*STATE_W]) : '0;
         s2_ff  <= row_valid_ff ? $signed(row_rd[2*STATE_W-1:STATE_W]) : '0;
         s3_ff  <= row_valid_ff ? $signed(row_rd[STATE_W-1:0]) : '0;
         avg_ff <= avg_sum[STATE_W:1];
      end
      if (cmd.mul) begin
         prod_ff <= prod_full;
      end
      if (cmd.acc) begin
         case (cmd.stage)
            STAGE_FIRST:  s1_ff <= acc_new;
            STAGE_SECOND: s2_ff <= acc_new;
            default:      s3_ff <= acc_new;
         endcase
      end
      if (cmd.commit) begin
         prev_new_ff <= clamp_val;
      end
      if (cmd.deliver) begin
         rsp_payload_ff.side_out   <= item_ff.side;
         rsp_payload_ff.voice_out  <= item_ff.voice;
         rsp_payload_ff.sample_out <= in_range_ff ? out_sat : '0;
      end
   end

   assign status.in_range = in_range_ff;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_payload     = rsp_payload_ff;

endmodule

FILE: rtl/alternating_iir_slew_shaper.sv
`timescale 1ns / 1ps
// Top level of the alternating IIR slew shaper: controller plus datapath.
// Depends on ais_pkg, ais_ctrl, ais_datapath and ais_ram.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_stall  req_payload_type (side, voice, sample_in)
//   rsp_      out        rsp_valid / rsp_stall  rsp_payload_type (side_out, voice_out,
//                                               sample_out)
//   csr_      in         csr_write              csr_index, csr_data (coefficients)
//
// The state RAM read is issued at the accepting edge; then LOAD fills the working
// registers, each of the three lowpass stages runs MUL and ACC through the single
// shared multiplier, COMMIT does the clamp and write-back, and DELIVER loads the
// result register; a voice out of range goes from LOAD straight to DELIVER. req_stall
// stays high until then, so a new transaction is accepted only when the last is done.
// Reset is synchronous; per-slot written flags make all filter state read as zero
// right after reset, so there is no clearing pass.
// A result waiting under rsp_stall holds the next one in its last step; that one is
// loaded at the edge where the waiting result is accepted, and the input is taken
// again in the cycle after.

module alternating_iir_slew_shaper
   import ais_pkg::*;
#(
   parameter int VOICES = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_payload_type      req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_payload_type      rsp_payload,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COEF_W-1:0]    csr_data
);

   // The controller sequences one transaction at a time; the datapath holds all
   // arithmetic and storage and reports only whether the voice is in range and
   // whether the result register can be loaded.
   ais_cmd_type    cmd;
   ais_status_type status;

   ais_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .status   (status),
      .cmd      (cmd)
   );

   ais_datapath #(
      .VOICES(VOICES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_payload(req_payload),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .status     (status),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

endmodule
